// ===== rtl/core/bebbc_pkg.sv =====
// ---------------------------------------------------------------------------
// bebbc_pkg
// Shared constants and codes for the big-endian byte buffer cursor.
// ---------------------------------------------------------------------------
package bebbc_pkg;

  // store depth; positions run 0..BUF_BYTES and must fit POS_W
  localparam int BUF_BYTES = 256;
  localparam int ADDR_W    = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam int POS_W     = 9;
  localparam int CNT_W     = 32;

  localparam int IN_USER_W  = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 88;

  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_UNREAD  = 3'd2,
    OP_POP     = 3'd3,
    OP_REWIND  = 3'd4,
    OP_RESTART = 3'd5
  } op_t;

  localparam logic [1:0] SZ_ONE = 2'd0;
  localparam logic [1:0] SZ_TWO = 2'd1;

endpackage

// ===== rtl/core/big_endian_byte_buffer_cursor.sv =====
// ---------------------------------------------------------------------------
// big_endian_byte_buffer_cursor
// Bounds-checked byte store with a front cursor and a movable end; one
// byte moves per cycle through a byte-wide store, MSB first.
// ---------------------------------------------------------------------------
// Channel  | Dir | Handshake                     | Payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser op+size, tdata value
// m_axis   | out | m_axis_tvalid / m_axis_tready | tdata result word
// cfg      | in  | cfg_wen                       | cfg_wdata buffer length
//
// A word runs one byte step per byte on the single store port, n steps, n being
// 1, 2 or 4 for read, write, unread and pop, and one step for the others;
// a flush state then lets the last read byte land, and a done state loads the
// output register. No new word is taken until that load; input is taken
// again once the result is loaded, even if it still waits. rst clears cursor,
// overrun count and flag and sets the end and the length to the store depth;
// the store is not cleared and has no clearing pass. A stalled result holds its word.
// ---------------------------------------------------------------------------
module big_endian_byte_buffer_cursor
  import bebbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // write_value[31:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,   // opcode[2:0], size_code[4:3]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // read_value[31:0], bytes_written[34:32], cursor[43:35],
  // end_position[52:44], overrun_count[84:53], at_end[85], zero[87:86]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_wen,
  input  logic [POS_W-1:0]      cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_DONE
  } state_t;

  state_t          state;
  op_t             op;
  logic [2:0]      steps;
  logic [2:0]      cnt;
  logic [31:0]     wsh;
  logic [31:0]     rv;
  logic [2:0]      bw;
  logic [POS_W-1:0] cur;
  logic [POS_W-1:0] endp;
  logic [CNT_W-1:0] ovr;
  logic            flag;
  logic [POS_W-1:0] cfg_len;
  logic            pend;
  logic            pend_hit;

  logic [7:0]      mem [BUF_BYTES];
  logic [7:0]      mem_rdata;
  logic            mem_we;
  logic [ADDR_W-1:0] mem_addr;

  logic [POS_W-1:0] cur_next;
  logic [POS_W-1:0] end_next;
  logic [CNT_W-1:0] ovr_next;
  logic [2:0]      bw_next;
  logic            flag_next;
  logic            hit;
  logic            rd_op;
  logic [CNT_W-1:0] ovr_sat;
  logic [POS_W-1:0] cur_dec;
  logic [POS_W-1:0] end_dec;
  logic [2:0]      n_bytes;
  logic            s_acc;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    case (s_axis_tuser[4:3])
      SZ_ONE:  n_bytes = 3'd1;
      SZ_TWO:  n_bytes = 3'd2;
      default: n_bytes = 3'd4;
    endcase
  end

  // one byte step of the current request
  always_comb begin
    hit       = cur < endp;
    ovr_sat   = (ovr == {CNT_W{1'b1}}) ? ovr : ovr + CNT_W'(1);
    cur_dec   = (cur != '0) ? cur - POS_W'(1) : cur;
    end_dec   = endp - POS_W'(1);
    cur_next  = cur;
    end_next  = endp;
    ovr_next  = ovr;
    bw_next   = bw;
    flag_next = flag;
    mem_we    = 1'b0;
    mem_addr  = cur[ADDR_W-1:0];
    rd_op     = 1'b0;
    case (op)
      OP_READ: begin
        rd_op = 1'b1;
        if (hit) begin
          cur_next = cur + POS_W'(1);
          if (cur + POS_W'(1) == endp) flag_next = 1'b1;
        end else begin
          ovr_next = ovr_sat;
        end
      end
      OP_WRITE: begin
        if (hit) begin
          mem_we   = 1'b1;
          cur_next = cur + POS_W'(1);
          bw_next  = bw + 3'd1;
          if (cur + POS_W'(1) == endp) flag_next = 1'b1;
        end else begin
          ovr_next = ovr_sat;
        end
      end
      OP_UNREAD: begin
        cur_next  = cur_dec;
        flag_next = (cur_dec >= endp);
      end
      OP_POP: begin
        rd_op    = 1'b1;
        mem_addr = end_dec[ADDR_W-1:0];
        if (hit) begin
          end_next = end_dec;
          if (cur == end_dec) flag_next = 1'b1;
        end else begin
          ovr_next = ovr_sat;
        end
      end
      OP_REWIND: begin
        cur_next  = '0;
        ovr_next  = '0;
        flag_next = (endp == '0);
      end
      OP_RESTART: begin
        end_next  = cfg_len;
        cur_next  = '0;
        ovr_next  = '0;
        flag_next = (cfg_len == '0);
      end
      default: begin
      end
    endcase
  end

  // byte store, registered read
  always_ff @(posedge clk) begin
    if (state == ST_RUN && mem_we) begin
      mem[mem_addr] <= wsh[31:24];
    end
    mem_rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cur           <= '0;
      endp          <= POS_W'(BUF_BYTES);
      ovr           <= '0;
      flag          <= (BUF_BYTES == 0);
      cfg_len       <= POS_W'(BUF_BYTES);
      pend          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        cfg_len <= (cfg_wdata > POS_W'(BUF_BYTES)) ? POS_W'(BUF_BYTES) : cfg_wdata;
      end
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) m_axis_tvalid <= 1'b0;

      // the byte read last cycle lands now; overrun bytes shift in as zero
      if (pend) rv <= {rv[23:0], (pend_hit ? mem_rdata : 8'h00)};
      pend <= (state == ST_RUN) && rd_op;

      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            op    <= op_t'(s_axis_tuser[2:0]);
            cnt   <= '0;
            rv    <= '0;
            bw    <= '0;
            state <= ST_RUN;
            case (s_axis_tuser[2:0])
              OP_READ, OP_WRITE, OP_UNREAD, OP_POP: steps <= n_bytes;
              default:                              steps <= 3'd1;
            endcase
            case (n_bytes)
              3'd1:    wsh <= {s_axis_tdata[7:0], 24'h0};
              3'd2:    wsh <= {s_axis_tdata[15:0], 16'h0};
              default: wsh <= s_axis_tdata;
            endcase
          end
        end
        ST_RUN: begin
          cur      <= cur_next;
          endp     <= end_next;
          ovr      <= ovr_next;
          bw       <= bw_next;
          flag     <= flag_next;
          pend_hit <= hit;
          wsh      <= {wsh[23:0], 8'h00};
          cnt      <= cnt + 3'd1;
          if (cnt + 3'd1 == steps) state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {2'b00, flag, ovr, endp, cur, bw, rv};
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_cur_le_end: assert property (@(posedge clk) disable iff (rst) cur <= endp)
    else $error("cursor passed the end");

  a_end_bound: assert property (@(posedge clk) disable iff (rst)
    endp <= POS_W'(BUF_BYTES))
    else $error("end beyond store depth");

  a_flag_clear: assert property (@(posedge clk) disable iff (rst) !flag |-> cur < endp)
    else $error("end flag clear with cursor at end");

  a_acc_run: assert property (@(posedge clk) disable iff (rst) s_acc |=> state == ST_RUN)
    else $error("accepted word did not start");

endmodule

// ===== sim/big_endian_byte_buffer_cursor_test.sv =====
// ---------------------------------------------------------------------------
// big_endian_byte_buffer_cursor_test
// Self-checking bench for the byte buffer cursor. Request words go in on the
// s_axis side and a behavioural model of the cursor, end, overrun count and
// store predicts each result word, which is checked field by field as it
// leaves on m_axis. Both sides idle and stall at random outside steady runs. Reads and pops
// never touch a store byte that has not been written since reset.
// ---------------------------------------------------------------------------
module big_endian_byte_buffer_cursor_test;
  import bebbc_pkg::*;

  localparam logic [2:0] OP_SPARE_6  = 3'd6;
  localparam logic [2:0] OP_SPARE_7  = 3'd7;
  localparam logic [1:0] SZ_FOUR     = 2'd2;
  localparam logic [1:0] SZ_FOUR_ALT = 2'd3;
  localparam int         STALL_LIMIT = 2000;
  localparam int         LEN_RESET   = 256;

  typedef struct {
    logic [31:0] read_value;
    logic [2:0]  bytes_written;
    logic [8:0]  cursor;
    logic [8:0]  end_position;
    logic [31:0] overrun_count;
    logic        at_end;
  } buffer_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // write_value
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;   // opcode, size_code
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // read_value, bytes_written, cursor, end_position, overrun_count, at_end
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_wen = 1'b0;
  logic [POS_W-1:0]      cfg_wdata = '0;

  // model state
  logic [7:0]  shadow_store [BUF_BYTES];
  bit          shadow_valid [BUF_BYTES];
  logic [8:0]  cursor_pos;
  logic [8:0]  end_pos;
  logic [31:0] lost_bytes;
  logic        end_flag;
  logic [8:0]  length_reg;

  buffer_result_t due_results [$];
  int  fail_count = 0;
  int  quiet_cycles = 0;
  int  rx_hold = 0;
  bit  rx_steady = 1'b0;
  bit  tx_steady = 1'b0;

  big_endian_byte_buffer_cursor dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int size_bytes(logic [1:0] sz);
    return (sz == SZ_ONE) ? 1 : (sz == SZ_TWO) ? 2 : 4;
  endfunction

  function automatic void count_lost();
    if (lost_bytes != 32'hFFFF_FFFF) lost_bytes++;
  endfunction

  function automatic void reload_end(logic [8:0] len);
    end_pos    = (len > LEN_RESET) ? 9'(LEN_RESET) : len;
    cursor_pos = '0;
    lost_bytes = '0;
    end_flag   = (end_pos == 0);
  endfunction

  // would this word read a store byte never written?
  function automatic bit hits_unwritten(logic [2:0] op, logic [1:0] sz);
    int c;
    int e;
    int i;
    c = int'(cursor_pos);
    e = int'(end_pos);
    for (i = 0; i < size_bytes(sz); i++) begin
      if (op == OP_READ && c < e) begin
        if (!shadow_valid[c[7:0]]) return 1'b1;
        c++;
      end else if (op == OP_POP && c < e) begin
        e--;
        if (!shadow_valid[e[7:0]]) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic buffer_result_t apply_word(logic [2:0] op, logic [1:0] sz,
                                                logic [31:0] val);
    buffer_result_t r;
    int n;
    int i;
    r.read_value    = '0;
    r.bytes_written = '0;
    n = size_bytes(sz);
    case (op)
      OP_READ: begin
        for (i = 0; i < n; i++) begin
          r.read_value = r.read_value << 8;
          if (cursor_pos < end_pos) begin
            r.read_value[7:0] = shadow_store[cursor_pos[7:0]];
            cursor_pos++;
            if (cursor_pos == end_pos) end_flag = 1'b1;
          end else begin
            count_lost();
          end
        end
      end
      OP_WRITE: begin
        for (i = 0; i < n; i++) begin
          if (cursor_pos < end_pos) begin
            shadow_store[cursor_pos[7:0]] = val[8*(n-1-i) +: 8];
            shadow_valid[cursor_pos[7:0]] = 1'b1;
            cursor_pos++;
            r.bytes_written++;
            if (cursor_pos == end_pos) end_flag = 1'b1;
          end else begin
            count_lost();
          end
        end
      end
      OP_UNREAD: begin
        for (i = 0; i < n; i++) begin
          if (cursor_pos != 0) cursor_pos--;
          end_flag = (cursor_pos >= end_pos);
        end
      end
      OP_POP: begin
        for (i = 0; i < n; i++) begin
          r.read_value = r.read_value << 8;
          if (cursor_pos < end_pos) begin
            end_pos--;
            r.read_value[7:0] = shadow_store[end_pos[7:0]];
            if (cursor_pos == end_pos) end_flag = 1'b1;
          end else begin
            count_lost();
          end
        end
      end
      OP_REWIND:  reload_end(end_pos);
      OP_RESTART: reload_end(length_reg);
      default: ;
    endcase
    r.cursor        = cursor_pos;
    r.end_position  = end_pos;
    r.overrun_count = lost_bytes;
    r.at_end        = end_flag;
    return r;
  endfunction

  // one request word; tvalid stays high into the next call when no gap follows
  task automatic push_word(logic [2:0] op, logic [1:0] sz, logic [31:0] val);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    due_results.push_back(apply_word(op, sz, val));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= {sz, op};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_length(logic [8:0] len);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    length_reg = len;
  endtask

  task automatic test_cursor_and_end();
    set_length(9'd6);
    push_word(OP_RESTART, SZ_ONE, $urandom());
    push_word(OP_WRITE, SZ_FOUR, 32'h0102_0304);
    push_word(OP_WRITE, SZ_TWO, 32'hFFFF_0506);    // fills up to the end
    push_word(OP_WRITE, SZ_ONE, 32'h0000_0077);    // past the end
    push_word(OP_READ, SZ_ONE, '0);
    push_word(OP_UNREAD, SZ_TWO, '0);
    push_word(OP_UNREAD, SZ_FOUR_ALT, '0);         // stops at zero
    push_word(OP_READ, SZ_FOUR, 32'hFFFF_FFFF);
    push_word(OP_POP, SZ_TWO, '0);                 // meets the cursor
    push_word(OP_POP, SZ_ONE, '0);
    push_word(OP_REWIND, SZ_ONE, '0);              // keeps the lowered end
    push_word(OP_POP, SZ_FOUR, '0);
    push_word(OP_READ, SZ_TWO, '0);
    push_word(OP_SPARE_6, SZ_FOUR, 32'hFFFF_FFFF);
    push_word(OP_SPARE_7, SZ_FOUR_ALT, 32'hA5A5_5A5A);
    push_word(OP_RESTART, SZ_TWO, '0);
    push_word(OP_READ, SZ_FOUR_ALT, '0);
  endtask

  task automatic test_length_extremes();
    set_length(9'd0);
    push_word(OP_RESTART, SZ_ONE, '0);
    push_word(OP_READ, SZ_ONE, '0);
    push_word(OP_UNREAD, SZ_ONE, '0);
    push_word(OP_POP, SZ_FOUR, '0);
    set_length(9'h1FF);                            // clamps to the store size
    push_word(OP_RESTART, SZ_ONE, '0);
    push_word(OP_WRITE, SZ_FOUR, 32'h0000_0000);
    set_length(9'(LEN_RESET));
    push_word(OP_RESTART, SZ_ONE, '0);
  endtask

  task automatic test_random_traffic(int count, logic [8:0] len, bit steady);
    logic [2:0] op;
    logic [1:0] sz;
    int r;
    set_length(len);
    tx_steady = steady;
    rx_steady = steady;
    push_word(OP_RESTART, SZ_ONE, $urandom());
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 32)      op = OP_READ;
      else if (r < 62) op = OP_WRITE;
      else if (r < 72) op = OP_UNREAD;
      else if (r < 82) op = OP_POP;
      else if (r < 88) op = OP_REWIND;
      else if (r < 93) op = OP_RESTART;
      else if (r < 96) op = OP_SPARE_6;
      else             op = OP_SPARE_7;
      sz = 2'($urandom_range(0, 3));
      if (hits_unwritten(op, sz)) op = OP_WRITE;
      push_word(op, sz, $urandom());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (!rx_steady && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      rx_hold = pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    buffer_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        $error("result word with none expected: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        check_field("read_value", want.read_value, m_axis_tdata[31:0]);
        check_field("bytes_written", 32'(want.bytes_written), 32'(m_axis_tdata[34:32]));
        check_field("cursor", 32'(want.cursor), 32'(m_axis_tdata[43:35]));
        check_field("end_position", 32'(want.end_position), 32'(m_axis_tdata[52:44]));
        check_field("overrun_count", want.overrun_count, m_axis_tdata[84:53]);
        check_field("at_end", 32'(want.at_end), 32'(m_axis_tdata[85]));
      end
    end
  end

  // watchdog on words moving through either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
    length_reg = 9'(LEN_RESET);
    reload_end(length_reg);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_cursor_and_end();
    test_length_extremes();
    test_random_traffic(160, 9'd256, 1'b0);
    test_random_traffic(120, 9'd24, 1'b0);
    test_random_traffic(60, 9'd3, 1'b1);
    test_random_traffic(30, 9'd0, 1'b0);
    test_random_traffic(90, 9'd300, 1'b0);
    test_random_traffic(90, 9'($urandom_range(1, 64)), 1'b0);

    wait_idle();
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bebbc_pkg.sv
rtl/core/big_endian_byte_buffer_cursor.sv
sim/big_endian_byte_buffer_cursor_test.sv
